FILE: src/fifo_queue_move_nth_to_rear_macros.svh
// assertion macros used by fifo_queue_move_nth_to_rear.sv
`ifndef FIFO_QUEUE_MOVE_NTH_TO_REAR_MACROS_SVH
`define FIFO_QUEUE_MOVE_NTH_TO_REAR_MACROS_SVH

// same-cycle implication
`define FQMR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fqmr assertion failed");

// next-cycle implication
`define FQMR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fqmr assertion failed");

`endif

FILE: src/fqmr_pkg.sv
`timescale 1ns / 1ps

package fqmr_pkg;

  localparam int DEPTH       = 16;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int SUM_W       = CNT_W + 1;
  localparam int DATA_W      = 32;
  localparam int POS_W       = 5;
  localparam int OCC_W       = 5;
  localparam int OP_W        = 2;
  localparam int ST_W        = 2;
  localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
  localparam logic [OP_W-1:0] OP_MOVE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_UNDER  = 2'd1;
  localparam logic [ST_W-1:0] ST_OVER   = 2'd2;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd3;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // physical slot of a logical position counted from the head
  function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] head,
                                                input logic [CNT_W-1:0] logical);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(logical);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

FILE: src/fifo_queue_move_nth_to_rear.sv
`timescale 1ns / 1ps
// channel  dir  handshake            payload
// s        in   s_tvalid / s_tready  tdata: value, position; tuser: operation
// m        out  m_tvalid / m_tready  tdata: data, status, occupancy
//
// enqueue, errors and no-op moves go straight to the result; dequeue passes S_DEQ (registered ram read)
// a move goes through S_MV_HOLD, then S_MV_SHIFT with one shift per cycle, then S_MV_LAST,
// through the single ram port pair and the shared slot adder
// synchronous reset empties the queue; ram contents are not cleared
// s_tready is low while an item is in work; a finished result waits for m_tready

`include "fifo_queue_move_nth_to_rear_macros.svh"

module fifo_queue_move_nth_to_rear (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [fqmr_pkg::IN_TDATA_W-1:0]       s_tdata,  // value[31:0], position[36:32]
  input  logic [fqmr_pkg::OP_W-1:0]             s_tuser,  // operation[1:0]
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [fqmr_pkg::OUT_TDATA_W-1:0]      m_tdata   // data[31:0], status[33:32],
                                                          // occupancy[38:34]
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DEQ      = 6'b000010,
    S_MV_HOLD  = 6'b000100,
    S_MV_SHIFT = 6'b001000,
    S_MV_LAST  = 6'b010000,
    S_DONE     = 6'b100000
  } state_t;

  state_t                           state, state_next;
  logic [fqmr_pkg::ADDR_W-1:0]      head, head_next;
  logic [fqmr_pkg::CNT_W-1:0]       count, count_next;
  logic [fqmr_pkg::CNT_W-1:0]       rd_log, rd_log_next;
  logic [fqmr_pkg::ADDR_W-1:0]      wr_slot, wr_slot_next;
  logic [fqmr_pkg::ADDR_W-1:0]      raddr_q;
  logic [fqmr_pkg::DATA_W-1:0]      held, held_next;
  logic [fqmr_pkg::DATA_W-1:0]      res_data, res_data_next;
  logic [fqmr_pkg::ST_W-1:0]        res_status, res_status_next;
  logic [fqmr_pkg::DATA_W-1:0]      out_data;
  logic [fqmr_pkg::ST_W-1:0]        out_status;
  logic [fqmr_pkg::OCC_W-1:0]       out_occ;

  logic [fqmr_pkg::DATA_W-1:0]      in_value;
  logic [fqmr_pkg::POS_W-1:0]       in_pos;
  logic [fqmr_pkg::CMP_W-1:0]       pos_c, count_c;
  logic                             accept;
  logic                             out_free;
  logic [fqmr_pkg::CNT_W-1:0]       logical;
  logic [fqmr_pkg::ADDR_W-1:0]      slot;
  fqmr_pkg::ram_req_t               ram_req;
  logic [fqmr_pkg::DATA_W-1:0]      rdata;

  assign in_value = s_tdata[fqmr_pkg::DATA_W-1:0];
  assign in_pos   = s_tdata[fqmr_pkg::DATA_W +: fqmr_pkg::POS_W];
  assign pos_c    = fqmr_pkg::CMP_W'(in_pos);
  assign count_c  = fqmr_pkg::CMP_W'(count);
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // shared slot adder input
  always_comb begin
    if (state == S_IDLE) begin
      case (s_tuser)
        fqmr_pkg::OP_ENQ:  logical = count;
        fqmr_pkg::OP_MOVE: logical = fqmr_pkg::CNT_W'(pos_c - fqmr_pkg::CMP_W'(1));
        default:           logical = '0;
      endcase
    end else begin
      logical = rd_log + fqmr_pkg::CNT_W'(1);
    end
  end

  assign slot = fqmr_pkg::slot_of(head, logical);

  always_comb begin
    state_next      = state;
    head_next       = head;
    count_next      = count;
    rd_log_next     = rd_log;
    wr_slot_next    = wr_slot;
    held_next       = held;
    res_data_next   = res_data;
    res_status_next = res_status;
    ram_req.we      = 1'b0;
    ram_req.waddr   = wr_slot;
    ram_req.wdata   = rdata;
    ram_req.raddr   = slot;
    case (state)
      S_IDLE: begin
        if (accept) begin
          res_data_next   = '0;
          res_status_next = fqmr_pkg::ST_OK;
          state_next      = S_DONE;
          case (s_tuser)
            fqmr_pkg::OP_ENQ: begin
              if (count >= fqmr_pkg::CNT_W'(fqmr_pkg::DEPTH)) begin
                res_status_next = fqmr_pkg::ST_OVER;
              end else begin
                ram_req.we    = 1'b1;
                ram_req.waddr = slot;
                ram_req.wdata = in_value;
                count_next    = count + fqmr_pkg::CNT_W'(1);
              end
            end
            fqmr_pkg::OP_DEQ: begin
              if (count == '0) begin
                res_status_next = fqmr_pkg::ST_UNDER;
              end else begin
                head_next  = (head == fqmr_pkg::ADDR_W'(fqmr_pkg::DEPTH - 1)) ?
                             '0 : head + fqmr_pkg::ADDR_W'(1);
                count_next = count - fqmr_pkg::CNT_W'(1);
                state_next = S_DEQ;
              end
            end
            fqmr_pkg::OP_MOVE: begin
              if (count <= fqmr_pkg::CNT_W'(1) || pos_c == count_c) begin
                res_status_next = fqmr_pkg::ST_OK;
              end else if (pos_c == '0 || pos_c > count_c) begin
                res_status_next = fqmr_pkg::ST_BADPOS;
              end else begin
                rd_log_next = logical;
                state_next  = S_MV_HOLD;
              end
            end
            default: begin
              res_status_next = fqmr_pkg::ST_OK;
            end
          endcase
        end
      end
      S_DEQ: begin
        res_data_next = rdata;
        state_next    = S_DONE;
      end
      S_MV_HOLD: begin
        held_next    = rdata;
        wr_slot_next = raddr_q;
        rd_log_next  = logical;
        state_next   = S_MV_SHIFT;
      end
      S_MV_SHIFT: begin
        ram_req.we   = 1'b1;
        wr_slot_next = raddr_q;
        if (logical < count) begin
          rd_log_next = logical;
        end else begin
          state_next = S_MV_LAST;
        end
      end
      S_MV_LAST: begin
        ram_req.we    = 1'b1;
        ram_req.wdata = held;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  fqmr_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_log     <= rd_log_next;
    wr_slot    <= wr_slot_next;
    raddr_q    <= ram_req.raddr;
    held       <= held_next;
    res_data   <= res_data_next;
    res_status <= res_status_next;
    if (state == S_DONE && out_free) begin
      out_data   <= res_data;
      out_status <= res_status;
      out_occ    <= fqmr_pkg::OCC_W'(count);
    end
  end

  assign m_tdata = {1'b0, out_occ, out_status, out_data};

  `FQMR_ASSERT_IMPL(a_count_bound, 1'b1, count <= fqmr_pkg::CNT_W'(fqmr_pkg::DEPTH))
  `FQMR_ASSERT_NEXT(a_busy_after_accept, accept, !s_tready)
  `FQMR_ASSERT_IMPL(a_over_full, m_tvalid && out_status == fqmr_pkg::ST_OVER, out_occ == fqmr_pkg::OCC_W'(fqmr_pkg::DEPTH))
  `FQMR_ASSERT_IMPL(a_under_empty, m_tvalid && out_status == fqmr_pkg::ST_UNDER, out_occ == '0 && out_data == '0)

endmodule

FILE: src/fqmr_ram.sv
`timescale 1ns / 1ps

module fqmr_ram (
  input  logic                         clk,
  input  fqmr_pkg::ram_req_t           req,
  output logic [fqmr_pkg::DATA_W-1:0]  rdata
);

  logic [fqmr_pkg::DATA_W-1:0] mem [fqmr_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import fqmr_pkg::*;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int IDLE_LIMIT = 1000;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [ST_W-1:0]   status;
    logic [OCC_W-1:0]  occupancy;
  } queue_result_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [OP_W-1:0]        s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;

  logic [DATA_W-1:0] model_words[$];
  queue_result_t     awaited_results[$];
  int                mismatch_count = 0;
  int                idle_cycles = 0;
  bit                s_burst = 0;
  bit                m_burst = 0;

  fifo_queue_move_nth_to_rear u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // updates the queue model and records the result the block must return
  task automatic apply_queue_op(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val,
                                input logic [POS_W-1:0] pos);
    queue_result_t     res;
    logic [DATA_W-1:0] held;
    int                cnt;
    res = '0;
    cnt = model_words.size();
    case (op)
      OP_ENQ: begin
        if (cnt >= DEPTH) begin
          res.status = ST_OVER;
        end else begin
          model_words.push_back(val);
        end
      end
      OP_DEQ: begin
        if (cnt == 0) begin
          res.status = ST_UNDER;
        end else begin
          res.data = model_words.pop_front();
        end
      end
      OP_MOVE: begin
        if (cnt <= 1 || int'(pos) == cnt) begin
          res.status = ST_OK;
        end else if (pos < 1 || int'(pos) > cnt) begin
          res.status = ST_BADPOS;
        end else begin
          held = model_words[pos - 1];
          model_words.delete(pos - 1);
          model_words.push_back(held);
        end
      end
      default: res.status = ST_OK;
    endcase
    res.occupancy = OCC_W'(model_words.size());
    awaited_results.push_back(res);
  endtask

  task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val,
                           input logic [POS_W-1:0] pos);
    int gap;
    gap = s_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W - DATA_W - POS_W){1'b0}}, pos, val};
    s_tuser  <= op;
    do @(posedge clk); while (s_tready !== 1'b1);
    apply_queue_op(op, val, pos);
    if ($urandom_range(0, 39) == 0) s_burst = !s_burst;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic test_empty_queue();
    send_item(OP_DEQ, 32'h0, 5'd0);
    send_item(OP_MOVE, 32'h0, 5'd0);
    send_item(OP_MOVE, 32'h0, 5'd31);
    send_item(OP_NONE, 32'hffff_ffff, 5'd31);
  endtask

  task automatic test_extremes();
    send_item(OP_ENQ, 32'h8000_0000, 5'd0);
    send_item(OP_MOVE, 32'h0, 5'd1);
    send_item(OP_MOVE, 32'h0, 5'd0);
    send_item(OP_ENQ, 32'h7fff_ffff, 5'd31);
    send_item(OP_MOVE, 32'h0, 5'd0);
    send_item(OP_MOVE, 32'h0, 5'd3);
    send_item(OP_MOVE, 32'h0, 5'd31);
    send_item(OP_MOVE, 32'h0, 5'd2);
    send_item(OP_MOVE, 32'h0, 5'd1);
    send_item(OP_ENQ, 32'hffff_ffff, 5'd16);
    send_item(OP_ENQ, 32'h0000_0000, 5'd0);
    send_item(OP_ENQ, 32'h5555_5555, 5'd10);
    send_item(OP_ENQ, 32'haaaa_aaaa, 5'd21);
    send_item(OP_MOVE, 32'h0, 5'd2);
    send_item(OP_NONE, 32'h1234_5678, 5'd2);
    repeat (7) send_item(OP_DEQ, $urandom(), 5'($urandom_range(0, 31)));
  endtask

  task automatic test_full_queue();
    repeat (DEPTH) send_item(OP_ENQ, $urandom(), 5'd0);
    send_item(OP_ENQ, 32'hdead_beef, 5'd0);
    send_item(OP_MOVE, 32'h0, 5'd1);
    send_item(OP_MOVE, 32'h0, 5'd16);
    send_item(OP_MOVE, 32'h0, 5'd17);
    send_item(OP_MOVE, 32'h0, 5'd8);
    drain_results();
    repeat (DEPTH + 1) send_item(OP_DEQ, 32'h0, 5'd0);
  endtask

  task automatic test_random_traffic(input int num_items);
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] val;
    logic [POS_W-1:0]  pos;
    bit                filling;
    int                cnt;
    int                pick;
    filling = 1;
    for (int i = 0; i < num_items; i++) begin
      cnt = model_words.size();
      if (cnt == DEPTH) filling = 0;
      if (cnt == 0) filling = 1;
      if ($urandom_range(0, 49) == 0) filling = !filling;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        op = OP_NONE;
      end else if (pick < 28) begin
        op = OP_MOVE;
      end else begin
        op = ($urandom_range(0, 99) < (filling ? 70 : 30)) ? OP_ENQ : OP_DEQ;
      end
      case ($urandom_range(0, 7))
        0: val = 32'h8000_0000;
        1: val = 32'h7fff_ffff;
        2: val = 32'hffff_ffff;
        default: val = $urandom();
      endcase
      pick = $urandom_range(0, 9);
      if (pick < 7 && cnt > 1) begin
        pos = POS_W'($urandom_range(1, cnt));
      end else if (pick < 8) begin
        pos = POS_W'(cnt + $urandom_range(0, 31 - cnt));
      end else begin
        pos = POS_W'($urandom_range(0, 31));
      end
      send_item(op, val, pos);
      if (i % 350 == 349) drain_results();
    end
  endtask

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= OP_ENQ;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_queue();
    test_extremes();
    test_full_queue();
    test_random_traffic(1400);
    drain_results();
    if (mismatch_count == 0) begin
      $display("** fifo_queue_move_nth_to_rear: PASSED **");
    end else begin
      $display("** fifo_queue_move_nth_to_rear: FAILED **");
    end
    $finish;
  end

  initial begin
    int stall;
    m_tready <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      stall = m_burst ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      if ($urandom_range(0, 39) == 0) m_burst = !m_burst;
    end
  end

  always @(posedge clk) begin
    queue_result_t got_result;
    queue_result_t want_result;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      got_result.data      = m_tdata[DATA_W-1:0];
      got_result.status    = m_tdata[DATA_W +: ST_W];
      got_result.occupancy = m_tdata[DATA_W + ST_W +: OCC_W];
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected item, data", got_result.data, '0);
      end else begin
        want_result = awaited_results.pop_front();
        if (got_result.data !== want_result.data)
          report_mismatch("data", got_result.data, want_result.data);
        if (got_result.status !== want_result.status)
          report_mismatch("status", DATA_W'(got_result.status), DATA_W'(want_result.status));
        if (got_result.occupancy !== want_result.occupancy)
          report_mismatch("occupancy", DATA_W'(got_result.occupancy),
                          DATA_W'(want_result.occupancy));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid === 1'b1 && s_tready === 1'b1) ||
        (m_tvalid === 1'b1 && m_tready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** fifo_queue_move_nth_to_rear: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

FILE: filelist.f
+incdir+src
src/fqmr_pkg.sv
src/fqmr_ram.sv
src/fifo_queue_move_nth_to_rear.sv
dv/tb.sv
